// ===== rtl/core/stbl_pkg.sv =====
// Shared constants, codes and types for the surface table bilinear lookup unit.
// Used by every module of the block except stbl_ram; it depends on nothing else.
package stbl_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 32;
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int COL_BITS    = $clog2(MAX_COLUMNS);
   localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
   localparam int CELLS       = MAX_ROWS * MAX_COLUMNS;
   localparam int VALUE_BITS  = 32;

   // operand width of the weight divider: difference of two values plus 2*pi
   localparam int WNUM_BITS = VALUE_BITS + 3;
   // Q1.16 weight, 0 .. 1.0 inclusive
   localparam int WGT_BITS  = 17;
   localparam int ONE_Q16   = 65536;

   localparam int HALF_PI = 102944;
   localparam int TWO_PI  = 411775;

   typedef enum logic [2:0] {
      FUNC_PHI_WR  = 3'd0,
      FUNC_HEAD_WR = 3'd1,
      FUNC_TAIL_WR = 3'd2,
      FUNC_CYL_WR  = 3'd3,
      FUNC_SURF_Q  = 3'd4,
      FUNC_RAD_Q   = 3'd5,
      FUNC_CYL_Q   = 3'd6,
      FUNC_UNUSED  = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      REG_ROW_COUNT  = 2'd0,
      REG_HEAD_COLS  = 2'd1,
      REG_TAIL_COLS  = 2'd2,
      REG_CYL_COLS   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      KEY_HEAD = 2'd0,
      KEY_TAIL = 2'd1,
      KEY_CYL  = 2'd2
   } key_sel_type;

   typedef enum logic [1:0] {
      RAD_HEAD_SURF   = 2'd0,
      RAD_HEAD_RADIAL = 2'd1,
      RAD_TAIL_SURF   = 2'd2,
      RAD_CYL         = 2'd3
   } rad_sel_type;

   typedef struct packed {
      logic                done;
      logic                flag;
      logic [WGT_BITS-1:0] weight;
   } wgt_result_type;

endpackage

// ===== rtl/core/stbl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module stbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/stbl_weight.sv =====
// Iterative weight divider: w = num/den in Q1.16, clamped to 0..1 with a flag.
// Uses stbl_pkg for widths and the result struct; one quotient bit per cycle.
module stbl_weight (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [stbl_pkg::WNUM_BITS-1:0] num,
   input  logic signed [stbl_pkg::WNUM_BITS-1:0] den,
   output stbl_pkg::wgt_result_type             result
);

   localparam int NB = stbl_pkg::WNUM_BITS;
   localparam int WB = stbl_pkg::WGT_BITS;

   logic                 busy_ff;
   logic                 done_ff;
   logic                 flag_ff;
   logic [3:0]           cnt_ff;
   logic [NB:0]          rem_ff;
   logic [NB-1:0]        den_ff;
   logic [WB-1:0]        q_ff;

   logic signed [NB-1:0] n_abs_in;
   logic signed [NB-1:0] d_abs_in;
   logic                 equal_in;
   logic [NB:0]          rem2_in;
   logic                 ge_in;

   // fold the sign of the divisor into the dividend
   always_comb begin
      n_abs_in = den[NB-1] ? -num : num;
      d_abs_in = den[NB-1] ? -den : den;
      equal_in = (n_abs_in == d_abs_in);
      rem2_in  = {rem_ff[NB-1:0], 1'b0};
      ge_in    = (rem2_in >= {1'b0, den_ff});
   end

   // start, special cases and restoring division steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            flag_ff <= 1'b0;
            if (den == '0) begin
               flag_ff <= 1'b1;
               q_ff    <= '0;
               done_ff <= 1'b1;
            end else if (n_abs_in < 0) begin
               flag_ff <= 1'b1;
               q_ff    <= '0;
               done_ff <= 1'b1;
            end else if (n_abs_in > d_abs_in) begin
               flag_ff <= 1'b1;
               q_ff    <= WB'(stbl_pkg::ONE_Q16);
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
               den_ff  <= d_abs_in;
               q_ff    <= {{(WB-1){1'b0}}, equal_in};
               rem_ff  <= {1'b0, equal_in ? (n_abs_in - d_abs_in) : n_abs_in};
            end
         end else if (busy_ff) begin
            rem_ff <= ge_in ? (rem2_in - {1'b0, den_ff}) : rem2_in;
            q_ff   <= {q_ff[WB-2:0], ge_in};
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign result.done   = done_ff;
   assign result.flag   = flag_ff;
   assign result.weight = q_ff;

endmodule

// ===== rtl/core/surface_table_bilinear_lookup_unit.sv =====
// Top level of the surface table bilinear lookup unit: stream channels, APB
// registers, table RAMs (stbl_ram), weight divider (stbl_weight), sequencer.
// Depends on stbl_pkg.
//
// Usage:
//   req_* carries one item per transaction: table writes (phi angle, head,
//   tail or cylinder grid entries) and queries (surface, radial, cylinder).
//   rsp_* returns exactly one result per item: the Q16.16 value plus the
//   out_of_range and bad_request flags. csr_* holds the row and column
//   counts; write them only while the block is idle.
//   Items are handled one at a time. A write or an unused code goes from
//   acceptance straight to the done state, which loads the output
//   register. A query first scans the rows in the row search and then
//   the columns of the lower row, both stepping through a registered RAM
//   read per entry, and ends with two divider passes and six products on
//   one shared multiplier.
//   Reset clears the control state and sets the counts to 64 and 32; the
//   tables hold nothing defined until written and need no clearing pass.
//   A result waits in the output register while rsp_tready is low; the next
//   item is still accepted and runs until its own result must be stored.
module surface_table_bilinear_lookup_unit (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: row[5:0], col[10:6], key_value[42:11], radius_a[74:43],
   //            radius_b[106:75], query_phi[138:107], query_pos[170:139], zero fill
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [175:0] req_tdata,
   // req_tuser: func[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata: value[31:0]
   output logic [31:0]  rsp_tdata,
   // rsp_tuser: out_of_range[0], bad_request[1]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int RB = stbl_pkg::ROW_BITS;
   localparam int CB = stbl_pkg::COL_BITS;
   localparam int AB = stbl_pkg::ADDR_BITS;
   localparam int NB = stbl_pkg::WNUM_BITS;
   localparam int WB = stbl_pkg::WGT_BITS;
   localparam int PB = 32 + WB + 1;
   localparam int SB = PB + 1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ROW_RD, ST_ROW_CMP, ST_ROW_A1, ST_ROW_A2, ST_ROW_A3, ST_WT_ROW,
      ST_BAND_RD, ST_BAND_CMP, ST_COL_RD, ST_COL_CMP, ST_COL_K1, ST_COL_K2,
      ST_COL_K3, ST_WT_COL, ST_CRN_RD, ST_CRN_CAP, ST_MUL, ST_ACC, ST_DONE
   } state_type;

   // configuration
   logic [6:0] row_count_ff;
   logic [5:0] head_cols_ff, tail_cols_ff, cyl_cols_ff;
   logic [6:0] nr_in;
   logic [5:0] hc_in, tc_in, cc_in;
   logic       csr_wr_in;

   // request fields
   stbl_pkg::func_type  req_func;
   logic [RB-1:0]       req_row;
   logic [CB-1:0]       req_col;
   logic [31:0]         req_key, req_ra, req_rb, req_phi, req_pos;
   logic                req_acc_in;
   logic                bad_in;
   logic [5:0]          lim_in;

   // sequencer state
   state_type                state_ff;
   stbl_pkg::func_type       func_ff;
   logic signed [31:0]       phi_ff, pos_ff;
   logic [6:0]               i_cnt_ff;
   logic [RB-1:0]            i1_ff, i2_ff;
   logic                     wrap_ff, found_ff;
   logic signed [31:0]       a1_ff, k1_ff;
   logic [5:0]               j_cnt_ff, nc_ff;
   logic [CB-1:0]            j1_ff, j2_ff;
   logic                     desc_ff, band_ff, flag_ff;
   stbl_pkg::key_sel_type    ksel_ff;
   stbl_pkg::rad_sel_type    rsel_ff;
   logic [WB-1:0]            wx_ff, wy_ff;
   logic [1:0]               c_ff;
   logic signed [31:0]       crn_ff [4];
   logic [2:0]               s_ff;
   logic signed [PB-1:0]     prod_ff;
   logic signed [SB-1:0]     acc_ff;
   logic signed [31:0]       lo_ff, hi_ff, val_ff;
   logic                     bad_ff;

   // output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_oor_ff, rsp_bad_ff;

   // RAM ports
   logic [AB-1:0] wr_addr_in, rd_addr_in;
   logic [RB-1:0] row_rd_addr_in;
   logic          row_we_in, head_we_in, tail_we_in, cyl_we_in;
   logic [31:0]   row_rdata, ht_rdata, hs_rdata, hr_rdata, tt_rdata, ts_rdata;
   logic [31:0]   cx_rdata, cr_rdata;
   logic signed [31:0] key_rdata_in, rad_rdata_in;
   stbl_pkg::rad_sel_type crn_tab_in;

   // weight divider
   logic                     wgt_start_in;
   logic signed [NB-1:0]     wgt_num_in, wgt_den_in;
   stbl_pkg::wgt_result_type wres;

   // datapath helpers
   logic                row_hit_in, col_hit_in, band_hit_in;
   logic [6:0]          nr_m1_in;
   logic [RB-1:0]       i1_in;
   logic signed [NB-1:0] phi_x, pos_x, a1_x, k1_x, rowd_x, keyd_x;
   logic signed [31:0]  mul_a_in;
   logic signed [WB:0]  mul_b_in;
   logic [WB-1:0]       mul_w_in;
   logic signed [SB-1:0] prod_x, sum_in, rnd_in;

   // clamp counts to their legal ranges
   always_comb begin
      nr_in = (row_count_ff < 7'd2) ? 7'd2 :
              (row_count_ff > 7'(stbl_pkg::MAX_ROWS)) ? 7'(stbl_pkg::MAX_ROWS) : row_count_ff;
      hc_in = (head_cols_ff < 6'd2) ? 6'd2 :
              (head_cols_ff > 6'(stbl_pkg::MAX_COLUMNS)) ? 6'(stbl_pkg::MAX_COLUMNS)
              : head_cols_ff;
      tc_in = (tail_cols_ff < 6'd2) ? 6'd2 :
              (tail_cols_ff > 6'(stbl_pkg::MAX_COLUMNS)) ? 6'(stbl_pkg::MAX_COLUMNS)
              : tail_cols_ff;
      cc_in = (cyl_cols_ff < 6'd2) ? 6'd2 :
              (cyl_cols_ff > 6'(stbl_pkg::MAX_COLUMNS)) ? 6'(stbl_pkg::MAX_COLUMNS)
              : cyl_cols_ff;
      nr_m1_in = nr_in - 7'd1;
   end

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr_in  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 7'(stbl_pkg::MAX_ROWS);
         head_cols_ff <= 6'(stbl_pkg::MAX_COLUMNS);
         tail_cols_ff <= 6'(stbl_pkg::MAX_COLUMNS);
         cyl_cols_ff  <= 6'(stbl_pkg::MAX_COLUMNS);
      end else if (csr_wr_in) begin
         unique case (stbl_pkg::reg_index_type'(csr_paddr[3:2]))
            stbl_pkg::REG_ROW_COUNT: row_count_ff <= csr_pwdata[6:0];
            stbl_pkg::REG_HEAD_COLS: head_cols_ff <= csr_pwdata[5:0];
            stbl_pkg::REG_TAIL_COLS: tail_cols_ff <= csr_pwdata[5:0];
            stbl_pkg::REG_CYL_COLS:  cyl_cols_ff  <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (stbl_pkg::reg_index_type'(csr_paddr[3:2]))
         stbl_pkg::REG_ROW_COUNT: csr_prdata = {25'd0, row_count_ff};
         stbl_pkg::REG_HEAD_COLS: csr_prdata = {26'd0, head_cols_ff};
         stbl_pkg::REG_TAIL_COLS: csr_prdata = {26'd0, tail_cols_ff};
         stbl_pkg::REG_CYL_COLS:  csr_prdata = {26'd0, cyl_cols_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // unpack the request
   assign req_func = stbl_pkg::func_type'(req_tuser[2:0]);
   assign req_row  = req_tdata[5:0];
   assign req_col  = req_tdata[10:6];
   assign req_key  = req_tdata[42:11];
   assign req_ra   = req_tdata[74:43];
   assign req_rb   = req_tdata[106:75];
   assign req_phi  = req_tdata[138:107];
   assign req_pos  = req_tdata[170:139];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc_in = req_tvalid && req_tready;

   // check write indexes and pick the table write enables
   always_comb begin
      unique case (req_func)
         stbl_pkg::FUNC_HEAD_WR: lim_in = hc_in;
         stbl_pkg::FUNC_TAIL_WR: lim_in = tc_in;
         default:                lim_in = cc_in;
      endcase
      case (req_func)
         stbl_pkg::FUNC_UNUSED: bad_in = 1'b1;
         stbl_pkg::FUNC_PHI_WR: bad_in = ({1'b0, req_row} >= nr_in);
         stbl_pkg::FUNC_HEAD_WR, stbl_pkg::FUNC_TAIL_WR, stbl_pkg::FUNC_CYL_WR:
            bad_in = ({1'b0, req_row} >= nr_in) || ({1'b0, req_col} >= lim_in);
         default: bad_in = 1'b0;
      endcase
      row_we_in  = req_acc_in && !bad_in && (req_func == stbl_pkg::FUNC_PHI_WR);
      head_we_in = req_acc_in && !bad_in && (req_func == stbl_pkg::FUNC_HEAD_WR);
      tail_we_in = req_acc_in && !bad_in && (req_func == stbl_pkg::FUNC_TAIL_WR);
      cyl_we_in  = req_acc_in && !bad_in && (req_func == stbl_pkg::FUNC_CYL_WR);
      wr_addr_in = {req_row, req_col};
   end

   // table memories
   stbl_ram #(.WIDTH(32), .DEPTH(stbl_pkg::MAX_ROWS)) u_row_angle (
      .clock(clock), .wr_en(row_we_in), .wr_addr(req_row), .wr_data(req_key),
      .rd_addr(row_rd_addr_in), .rd_data(row_rdata));
   stbl_ram #(.WIDTH(32), .DEPTH(stbl_pkg::CELLS)) u_head_theta (
      .clock(clock), .wr_en(head_we_in), .wr_addr(wr_addr_in), .wr_data(req_key),
      .rd_addr(rd_addr_in), .rd_data(ht_rdata));
   stbl_ram #(.WIDTH(32), .DEPTH(stbl_pkg::CELLS)) u_head_surf (
      .clock(clock), .wr_en(head_we_in), .wr_addr(wr_addr_in), .wr_data(req_ra),
      .rd_addr(rd_addr_in), .rd_data(hs_rdata));
   stbl_ram #(.WIDTH(32), .DEPTH(stbl_pkg::CELLS)) u_head_radial (
      .clock(clock), .wr_en(head_we_in), .wr_addr(wr_addr_in), .wr_data(req_rb),
      .rd_addr(rd_addr_in), .rd_data(hr_rdata));
   stbl_ram #(.WIDTH(32), .DEPTH(stbl_pkg::CELLS)) u_tail_theta (
      .clock(clock), .wr_en(tail_we_in), .wr_addr(wr_addr_in), .wr_data(req_key),
      .rd_addr(rd_addr_in), .rd_data(tt_rdata));
   stbl_ram #(.WIDTH(32), .DEPTH(stbl_pkg::CELLS)) u_tail_surf (
      .clock(clock), .wr_en(tail_we_in), .wr_addr(wr_addr_in), .wr_data(req_ra),
      .rd_addr(rd_addr_in), .rd_data(ts_rdata));
   stbl_ram #(.WIDTH(32), .DEPTH(stbl_pkg::CELLS)) u_cyl_x (
      .clock(clock), .wr_en(cyl_we_in), .wr_addr(wr_addr_in), .wr_data(req_key),
      .rd_addr(rd_addr_in), .rd_data(cx_rdata));
   stbl_ram #(.WIDTH(32), .DEPTH(stbl_pkg::CELLS)) u_cyl_radius (
      .clock(clock), .wr_en(cyl_we_in), .wr_addr(wr_addr_in), .wr_data(req_ra),
      .rd_addr(rd_addr_in), .rd_data(cr_rdata));

   // select read addresses and read data
   always_comb begin
      row_rd_addr_in = i_cnt_ff[RB-1:0];
      if (state_ff == ST_ROW_A1) row_rd_addr_in = i1_ff;
      else if (state_ff == ST_ROW_A2) row_rd_addr_in = i2_ff;

      case (state_ff)
         ST_BAND_RD: rd_addr_in = '0;
         ST_COL_K1:  rd_addr_in = {i1_ff, j1_ff};
         ST_COL_K2:  rd_addr_in = {i1_ff, j2_ff};
         ST_CRN_RD:  rd_addr_in = {c_ff[1] ? i2_ff : i1_ff, c_ff[0] ? j2_ff : j1_ff};
         default:    rd_addr_in = {i1_ff, j_cnt_ff[CB-1:0]};
      endcase

      case (ksel_ff)
         stbl_pkg::KEY_TAIL: key_rdata_in = tt_rdata;
         stbl_pkg::KEY_CYL:  key_rdata_in = cx_rdata;
         default:            key_rdata_in = ht_rdata;
      endcase

      if (band_ff) begin
         crn_tab_in = c_ff[0] ? stbl_pkg::RAD_TAIL_SURF : stbl_pkg::RAD_HEAD_SURF;
      end else begin
         crn_tab_in = rsel_ff;
      end
      case (crn_tab_in)
         stbl_pkg::RAD_HEAD_RADIAL: rad_rdata_in = hr_rdata;
         stbl_pkg::RAD_TAIL_SURF:   rad_rdata_in = ts_rdata;
         stbl_pkg::RAD_CYL:         rad_rdata_in = cr_rdata;
         default:                   rad_rdata_in = hs_rdata;
      endcase
   end

   // search compares and divider operands
   always_comb begin
      phi_x  = NB'(phi_ff);
      pos_x  = NB'(pos_ff);
      a1_x   = NB'(a1_ff);
      k1_x   = NB'(k1_ff);
      rowd_x = NB'($signed(row_rdata));
      keyd_x = NB'(key_rdata_in);

      row_hit_in  = ($signed(row_rdata) > phi_ff);
      col_hit_in  = desc_ff ? (key_rdata_in < pos_ff) : (key_rdata_in > pos_ff);
      band_hit_in = (pos_ff < key_rdata_in);
      i1_in       = (i_cnt_ff == 7'd0) ? nr_m1_in[RB-1:0] : RB'(i_cnt_ff - 7'd1);

      case (state_ff)
         ST_ROW_A3: begin
            wgt_num_in = phi_x - a1_x + ((wrap_ff && found_ff) ? NB'(stbl_pkg::TWO_PI) : '0);
            wgt_den_in = rowd_x - a1_x + (wrap_ff ? NB'(stbl_pkg::TWO_PI) : '0);
         end
         ST_BAND_CMP: begin
            wgt_num_in = pos_x - NB'(stbl_pkg::HALF_PI);
            wgt_den_in = keyd_x - NB'(stbl_pkg::HALF_PI);
         end
         default: begin
            wgt_num_in = pos_x - k1_x;
            wgt_den_in = keyd_x - k1_x;
         end
      endcase
      wgt_start_in = (state_ff == ST_ROW_A3) || (state_ff == ST_COL_K3) ||
                     ((state_ff == ST_BAND_CMP) && band_hit_in);
   end

   stbl_weight u_weight (
      .clock(clock), .reset(reset), .start(wgt_start_in),
      .num(wgt_num_in), .den(wgt_den_in), .result(wres));

   // shared multiplier operands and accumulator
   always_comb begin
      mul_w_in = (s_ff < 3'd4) ? wy_ff : wx_ff;
      case (s_ff)
         3'd4:    mul_a_in = lo_ff;
         3'd5:    mul_a_in = hi_ff;
         default: mul_a_in = crn_ff[s_ff[1:0]];
      endcase
      mul_b_in = s_ff[0] ? $signed({1'b0, mul_w_in})
                         : $signed((WB+1)'(stbl_pkg::ONE_Q16) - {1'b0, mul_w_in});
      prod_x   = SB'(prod_ff);
      sum_in   = s_ff[0] ? (acc_ff + prod_x) : prod_x;
      rnd_in   = sum_in + SB'(32768);
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc_in) begin
                  func_ff <= req_func;
                  phi_ff  <= req_phi;
                  pos_ff  <= req_pos;
                  flag_ff <= 1'b0;
                  band_ff <= 1'b0;
                  bad_ff  <= bad_in;
                  val_ff  <= '0;
                  i_cnt_ff <= '0;
                  if (req_func == stbl_pkg::FUNC_SURF_Q || req_func == stbl_pkg::FUNC_RAD_Q ||
                      req_func == stbl_pkg::FUNC_CYL_Q) begin
                     state_ff <= ST_ROW_RD;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_ROW_RD: state_ff <= ST_ROW_CMP;
            ST_ROW_CMP: begin
               if (row_hit_in) begin
                  i2_ff    <= i_cnt_ff[RB-1:0];
                  i1_ff    <= i1_in;
                  found_ff <= 1'b1;
                  wrap_ff  <= (i_cnt_ff == 7'd0);
                  state_ff <= ST_ROW_A1;
               end else if (i_cnt_ff == nr_m1_in) begin
                  i2_ff    <= '0;
                  i1_ff    <= nr_m1_in[RB-1:0];
                  found_ff <= 1'b0;
                  wrap_ff  <= 1'b1;
                  state_ff <= ST_ROW_A1;
               end else begin
                  i_cnt_ff <= i_cnt_ff + 7'd1;
                  state_ff <= ST_ROW_RD;
               end
            end
            ST_ROW_A1: state_ff <= ST_ROW_A2;
            ST_ROW_A2: begin
               a1_ff    <= $signed(row_rdata);
               state_ff <= ST_ROW_A3;
            end
            ST_ROW_A3: state_ff <= ST_WT_ROW;
            ST_WT_ROW: begin
               if (wres.done) begin
                  wx_ff    <= wres.weight;
                  flag_ff  <= flag_ff | wres.flag;
                  j_cnt_ff <= '0;
                  desc_ff  <= 1'b0;
                  if (func_ff == stbl_pkg::FUNC_RAD_Q) begin
                     ksel_ff  <= stbl_pkg::KEY_HEAD;
                     rsel_ff  <= stbl_pkg::RAD_HEAD_RADIAL;
                     nc_ff    <= hc_in;
                     state_ff <= ST_COL_RD;
                  end else if (func_ff == stbl_pkg::FUNC_CYL_Q) begin
                     ksel_ff  <= stbl_pkg::KEY_CYL;
                     rsel_ff  <= stbl_pkg::RAD_CYL;
                     nc_ff    <= cc_in;
                     desc_ff  <= 1'b1;
                     state_ff <= ST_COL_RD;
                  end else if (pos_ff < 32'sd102944) begin
                     ksel_ff  <= stbl_pkg::KEY_HEAD;
                     rsel_ff  <= stbl_pkg::RAD_HEAD_SURF;
                     nc_ff    <= hc_in;
                     state_ff <= ST_COL_RD;
                  end else begin
                     ksel_ff  <= stbl_pkg::KEY_TAIL;
                     state_ff <= ST_BAND_RD;
                  end
               end
            end
            ST_BAND_RD: state_ff <= ST_BAND_CMP;
            ST_BAND_CMP: begin
               if (band_hit_in) begin
                  band_ff  <= 1'b1;
                  j1_ff    <= CB'(hc_in - 6'd1);
                  j2_ff    <= '0;
                  state_ff <= ST_WT_COL;
               end else begin
                  rsel_ff  <= stbl_pkg::RAD_TAIL_SURF;
                  nc_ff    <= tc_in;
                  state_ff <= ST_COL_RD;
               end
            end
            ST_COL_RD: state_ff <= ST_COL_CMP;
            ST_COL_CMP: begin
               if (col_hit_in) begin
                  j1_ff    <= (j_cnt_ff == 6'd0) ? '0 : CB'(j_cnt_ff - 6'd1);
                  j2_ff    <= (j_cnt_ff == 6'd0) ? CB'(1) : j_cnt_ff[CB-1:0];
                  state_ff <= ST_COL_K1;
               end else if (j_cnt_ff == nc_ff - 6'd1) begin
                  j1_ff    <= CB'(nc_ff - 6'd2);
                  j2_ff    <= CB'(nc_ff - 6'd1);
                  state_ff <= ST_COL_K1;
               end else begin
                  j_cnt_ff <= j_cnt_ff + 6'd1;
                  state_ff <= ST_COL_RD;
               end
            end
            ST_COL_K1: state_ff <= ST_COL_K2;
            ST_COL_K2: begin
               k1_ff    <= key_rdata_in;
               state_ff <= ST_COL_K3;
            end
            ST_COL_K3: state_ff <= ST_WT_COL;
            ST_WT_COL: begin
               if (wres.done) begin
                  wy_ff    <= wres.weight;
                  flag_ff  <= flag_ff | wres.flag;
                  c_ff     <= '0;
                  state_ff <= ST_CRN_RD;
               end
            end
            ST_CRN_RD: state_ff <= ST_CRN_CAP;
            ST_CRN_CAP: begin
               crn_ff[c_ff] <= rad_rdata_in;
               if (c_ff == 2'd3) begin
                  s_ff     <= '0;
                  state_ff <= ST_MUL;
               end else begin
                  c_ff     <= c_ff + 2'd1;
                  state_ff <= ST_CRN_RD;
               end
            end
            ST_MUL: begin
               prod_ff  <= mul_a_in * mul_b_in;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff <= sum_in;
               s_ff   <= s_ff + 3'd1;
               state_ff <= ST_MUL;
               if (s_ff == 3'd1) lo_ff <= rnd_in[47:16];
               if (s_ff == 3'd3) hi_ff <= rnd_in[47:16];
               if (s_ff == 3'd5) begin
                  val_ff   <= rnd_in[47:16];
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= val_ff;
                  rsp_oor_ff   <= flag_ff;
                  rsp_bad_ff   <= bad_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_oor_ff};

   // a bad request never carries a value or a range flag
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_value_ff == '0 && !rsp_oor_ff)
      else $error("bad request result carries data");

   // the divider only reports while the sequencer waits for it
   a_wgt_done_wait: assert property (@(posedge clock) disable iff (reset)
      wres.done |-> (state_ff == ST_WT_ROW || state_ff == ST_WT_COL))
      else $error("weight result arrived outside a wait state");

   // tables are written only by an accepted write transaction
   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      (row_we_in || head_we_in || tail_we_in || cyl_we_in) |-> req_acc_in && !bad_in)
      else $error("table write without accepted transaction");

   // the row scan stays inside the rows in use
   a_row_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROW_CMP |-> i_cnt_ff < nr_in)
      else $error("row search ran past the row count");

   // a finished result is not lost while the receiver stalls
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid_ff && !rsp_tready |=> state_ff == ST_DONE)
      else $error("result dropped while output register full");

endmodule

// ===== verif/stbl_checker.sv =====
// Checker for the surface table bilinear lookup unit: watches the request, result
// and register channels, predicts each result from its own copy of the tables.
// Depends on stbl_pkg.
module stbl_checker
   import stbl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [175:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           pending,
   output int           fail_count,
   output int           query_count
);

   typedef struct packed {
      logic [31:0] value;
      logic        out_of_range;
      logic        bad_request;
   } lookup_result_type;

   // register copies, raw as written
   logic [6:0] row_count_reg;
   logic [5:0] head_cols_reg, tail_cols_reg, cyl_cols_reg;

   // shadow tables, flat index row*MAX_COLUMNS+col
   int row_angle[MAX_ROWS];
   int head_theta[CELLS], head_surf[CELLS], head_radial[CELLS];
   int tail_theta[CELLS], tail_surf[CELLS];
   int cyl_x[CELLS], cyl_radius[CELLS];

   lookup_result_type expected_q[$];

   function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
      if (v < 2) return 2;
      return (v > hi) ? hi : v;
   endfunction

   // round half up from Q32 products to Q16.16
   function automatic longint round_q16(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint weight_q16(longint num, longint den, inout bit flag);
      if (den == 0) begin
         flag = 1;
         return 0;
      end
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num < 0) begin
         flag = 1;
         return 0;
      end
      if (num > den) begin
         flag = 1;
         return ONE_Q16;
      end
      return (num * ONE_Q16) / den;
   endfunction

   function automatic longint blend_corners(longint r11, longint r12, longint r21,
                                            longint r22, longint wx, longint wy);
      longint lo, hi;
      lo = round_q16(r11 * (ONE_Q16 - wy) + r12 * wy);
      hi = round_q16(r21 * (ONE_Q16 - wy) + r22 * wy);
      return round_q16(lo * (ONE_Q16 - wx) + hi * wx);
   endfunction

   function automatic longint key_at(key_sel_type sel, int idx);
      case (sel)
         KEY_HEAD: return head_theta[idx];
         KEY_TAIL: return tail_theta[idx];
         default:  return cyl_x[idx];
      endcase
   endfunction

   function automatic longint radius_at(rad_sel_type sel, int idx);
      case (sel)
         RAD_HEAD_SURF:   return head_surf[idx];
         RAD_HEAD_RADIAL: return head_radial[idx];
         RAD_TAIL_SURF:   return tail_surf[idx];
         default:         return cyl_radius[idx];
      endcase
   endfunction

   // column search in the lower row, then bilinear blend of the four corners
   function automatic longint grid_lookup(key_sel_type ks, rad_sel_type rs, int nc,
                                          longint pos, bit descending, int i1, int i2,
                                          longint wx, inout bit flag);
      int b1, b2, j1, j2;
      longint k, wy;
      b1 = i1 * MAX_COLUMNS;
      b2 = i2 * MAX_COLUMNS;
      j1 = nc - 2;
      j2 = nc - 1;
      for (int c = 0; c < nc; c++) begin
         k = key_at(ks, b1 + c);
         if (descending ? (k < pos) : (k > pos)) begin
            j1 = (c == 0) ? 0 : c - 1;
            j2 = (c == 0) ? 1 : c;
            break;
         end
      end
      wy = weight_q16(pos - key_at(ks, b1 + j1), key_at(ks, b1 + j2) - key_at(ks, b1 + j1),
                      flag);
      return blend_corners(radius_at(rs, b1 + j1), radius_at(rs, b1 + j2),
                           radius_at(rs, b2 + j1), radius_at(rs, b2 + j2), wx, wy);
   endfunction

   function automatic lookup_result_type predict_lookup(func_type func, logic [175:0] d);
      lookup_result_type res;
      int row, col, idx, nr, hc, tc, cc, lim, i1, i2;
      longint key, ra, rb, phi, pos, num, den, wx, wy, value;
      bit flag, bad, found, wrap;
      row = d[5:0];
      col = d[10:6];
      key = $signed(d[42:11]);
      ra  = $signed(d[74:43]);
      rb  = $signed(d[106:75]);
      phi = $signed(d[138:107]);
      pos = $signed(d[170:139]);
      nr = clamp_count(row_count_reg, MAX_ROWS);
      hc = clamp_count(head_cols_reg, MAX_COLUMNS);
      tc = clamp_count(tail_cols_reg, MAX_COLUMNS);
      cc = clamp_count(cyl_cols_reg, MAX_COLUMNS);
      idx = row * MAX_COLUMNS + col;
      value = 0;
      flag = 0;
      bad = 0;
      case (func)
         FUNC_PHI_WR, FUNC_HEAD_WR, FUNC_TAIL_WR, FUNC_CYL_WR: begin
            lim = (func == FUNC_HEAD_WR) ? hc : (func == FUNC_TAIL_WR) ? tc : cc;
            if (row >= nr || (func != FUNC_PHI_WR && col >= lim)) bad = 1;
            else if (func == FUNC_PHI_WR) row_angle[row] = int'(key);
            else if (func == FUNC_HEAD_WR) begin
               head_theta[idx] = int'(key);
               head_surf[idx] = int'(ra);
               head_radial[idx] = int'(rb);
            end else if (func == FUNC_TAIL_WR) begin
               tail_theta[idx] = int'(key);
               tail_surf[idx] = int'(ra);
            end else begin
               cyl_x[idx] = int'(key);
               cyl_radius[idx] = int'(ra);
            end
         end
         FUNC_UNUSED: bad = 1;
         default: begin
            // bracket phi between rows, wrapping the last row onto row 0
            i2 = 0;
            found = 0;
            for (int r = 0; r < nr; r++) begin
               if (row_angle[r] > phi) begin
                  i2 = r;
                  found = 1;
                  break;
               end
            end
            wrap = (i2 == 0);
            i1 = wrap ? nr - 1 : i2 - 1;
            num = phi - row_angle[i1];
            den = longint'(row_angle[i2]) - row_angle[i1];
            if (wrap) begin
               den += TWO_PI;
               if (found) num += TWO_PI;
            end
            wx = weight_q16(num, den, flag);
            if (func == FUNC_RAD_Q)
               value = grid_lookup(KEY_HEAD, RAD_HEAD_RADIAL, hc, pos, 0, i1, i2, wx, flag);
            else if (func == FUNC_CYL_Q)
               value = grid_lookup(KEY_CYL, RAD_CYL, cc, pos, 1, i1, i2, wx, flag);
            else if (pos < HALF_PI)
               value = grid_lookup(KEY_HEAD, RAD_HEAD_SURF, hc, pos, 0, i1, i2, wx, flag);
            else if (pos < tail_theta[0]) begin
               // band between the head grid and the first tail angle
               wy = weight_q16(pos - HALF_PI, longint'(tail_theta[0]) - HALF_PI, flag);
               value = blend_corners(head_surf[i1 * MAX_COLUMNS + hc - 1],
                                     tail_surf[i1 * MAX_COLUMNS],
                                     head_surf[i2 * MAX_COLUMNS + hc - 1],
                                     tail_surf[i2 * MAX_COLUMNS], wx, wy);
            end else
               value = grid_lookup(KEY_TAIL, RAD_TAIL_SURF, tc, pos, 0, i1, i2, wx, flag);
         end
      endcase
      if (value > 64'sd2147483647) value = 64'sd2147483647;
      if (value < -64'sd2147483648) value = -64'sd2147483648;
      res.value = value[31:0];
      res.out_of_range = flag;
      res.bad_request = bad;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (fail_count < 30)
         $display("[%0t] mismatch in %s: expected %h, got %h", $time, what, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      query_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         row_count_reg <= 7'd64;
         head_cols_reg <= 6'd32;
         tail_cols_reg <= 6'd32;
         cyl_cols_reg <= 6'd32;
         expected_q.delete();
      end else begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_ROW_COUNT: row_count_reg <= csr_pwdata[6:0];
               REG_HEAD_COLS: head_cols_reg <= csr_pwdata[5:0];
               REG_TAIL_COLS: tail_cols_reg <= csr_pwdata[5:0];
               REG_CYL_COLS:  cyl_cols_reg <= csr_pwdata[5:0];
            endcase
         end
         // predict each accepted request transaction
         if (req_tvalid && req_tready) begin
            expected_q.push_back(predict_lookup(func_type'(req_tuser), req_tdata));
            if (req_tuser inside {FUNC_SURF_Q, FUNC_RAD_Q, FUNC_CYL_Q}) query_count++;
         end
         // compare each accepted result transaction with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0)
               report_mismatch("unexpected result", 32'h0, rsp_tdata);
            else begin
               want = expected_q.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("value", want.value, rsp_tdata);
               if (rsp_tuser[0] !== want.out_of_range)
                  report_mismatch("out_of_range", want.out_of_range, rsp_tuser[0]);
               if (rsp_tuser[1] !== want.bad_request)
                  report_mismatch("bad_request", want.bad_request, rsp_tuser[1]);
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

// ===== verif/testbench.sv =====
// Top of the lookup unit testbench: clock, reset, register phases, table fills,
// directed and random request traffic, result back-pressure and the verdict.
// Depends on stbl_pkg, surface_table_bilinear_lookup_unit and stbl_checker.
module testbench;
   import stbl_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;
   localparam int RANDOM_PER_PHASE = 340;
   localparam int PHASES = 6;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;
   logic [2:0]   req_tuser = FUNC_PHI_WR;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [31:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel = 0;
   logic         csr_penable = 0;
   logic         csr_pwrite = 0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int  pending, fail_count, query_count;
   int  cycle_count = 0;
   int  item_count = 0;
   bit  idle_off = 0;
   bit  hold_request = 0;

   // stimulus view of the current tables, for well-formed queries
   int  eff_rows, eff_head, eff_tail, eff_cyl;
   int  phi_lo, phi_hi, head_lo, head_hi, tail_lo, tail_hi, cyl_lo, cyl_hi;

   surface_table_bilinear_lookup_unit u_dut (.*);

   stbl_checker u_checker (.*);

   always #10 clock = ~clock;

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int between(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
      if (v < 2) return 2;
      return (v > hi) ? hi : v;
   endfunction

   function automatic int draw_gap();
      return idle_off ? 0 : int'($urandom_range(0, 12));
   endfunction

   // result side: random stalls, one long hold-off when asked
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 0;
            repeat (800) @(posedge clock);
         end else begin
            gap = draw_gap();
            if (gap > 0) begin
               rsp_tready <= 0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_item(func_type func, int row, int col, int key, int ra, int rb,
                            int phi, int pos);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tuser <= func;
      req_tdata <= {5'b0, pos, phi, rb, ra, key, col[4:0], row[5:0]};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
   endtask

   task automatic end_burst();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type idx, int value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   function automatic int draw_radius();
      return ($urandom_range(0, 15) == 0) ? int'($urandom()) : between(16384, 2000000);
   endfunction

   // fill every entry in use with sorted keys; equal neighbors give zero spans
   task automatic fill_tables();
      int a, t, x;
      a = -int'($urandom_range(0, 150000));
      phi_lo = a;
      for (int r = 0; r < eff_rows; r++) begin
         send_item(FUNC_PHI_WR, r, 0, a, 0, 0, 0, 0);
         phi_hi = a;
         if ($urandom_range(0, 9) != 0) a += between(1, 380000 / eff_rows + 1);
      end
      for (int r = 0; r < eff_rows; r++) begin
         t = -int'($urandom_range(0, 20000));
         head_lo = t;
         for (int c = 0; c < eff_head; c++) begin
            send_item(FUNC_HEAD_WR, r, c, t, draw_radius(), draw_radius(), 0, 0);
            head_hi = t;
            if ($urandom_range(0, 9) != 0) t += between(1, 100000 / eff_head + 1);
         end
         t = HALF_PI + between(1, 40000);
         tail_lo = t;
         for (int c = 0; c < eff_tail; c++) begin
            send_item(FUNC_TAIL_WR, r, c, t, draw_radius(), 0, 0, 0);
            tail_hi = t;
            if ($urandom_range(0, 9) != 0) t += between(1, 110000 / eff_tail + 1);
         end
         x = between(200000, 300000);
         cyl_hi = x;
         for (int c = 0; c < eff_cyl; c++) begin
            send_item(FUNC_CYL_WR, r, c, x, draw_radius(), 0, 0, 0);
            cyl_lo = x;
            if ($urandom_range(0, 9) != 0) x -= between(1, 500000 / eff_cyl + 1);
         end
      end
   endtask

   task automatic directed_items();
      int mid;
      mid = phi_lo + (phi_hi - phi_lo) / 2;
      // row wrap with phi below the first angle, and with no row above phi
      send_item(FUNC_SURF_Q, 0, 0, 0, 0, 0, phi_lo - 1000, -100000);
      send_item(FUNC_SURF_Q, 0, 0, 0, 0, 0, phi_hi + 5000, HALF_PI);
      // exact row angle, first tail angle, band interior
      send_item(FUNC_SURF_Q, 0, 0, 0, 0, 0, phi_lo, tail_lo);
      send_item(FUNC_SURF_Q, 0, 0, 0, 0, 0, mid, HALF_PI + (tail_lo - HALF_PI) / 2);
      // field extremes
      send_item(FUNC_SURF_Q, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff);
      send_item(FUNC_RAD_Q, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff);
      send_item(FUNC_RAD_Q, 0, 0, 0, 0, 0, mid, 32'h80000000);
      send_item(FUNC_CYL_Q, 0, 0, 0, 0, 0, mid, 32'h7fffffff);
      send_item(FUNC_CYL_Q, 0, 0, 0, 0, 0, mid, 32'h80000000);
      send_item(FUNC_UNUSED, 63, 31, -1, -1, -1, -1, -1);
      // out-of-range write indexes
      send_item(FUNC_PHI_WR, 63, 0, 5, 0, 0, 0, 0);
      send_item(FUNC_HEAD_WR, 0, 31, 5, 5, 5, 0, 0);
      send_item(FUNC_TAIL_WR, eff_rows, 0, 5, 5, 0, 0, 0);
      send_item(FUNC_CYL_WR, 0, eff_cyl, 5, 5, 0, 0, 0);
      // extreme radii, then read them back
      send_item(FUNC_HEAD_WR, 0, 1, head_hi, 32'h7fffffff, 32'h80000000, 0, 0);
      send_item(FUNC_RAD_Q, 0, 0, 0, 0, 0, phi_lo, head_hi);
      send_item(FUNC_SURF_Q, 0, 0, 0, 0, 0, phi_lo, head_lo);
      end_burst();
   endtask

   task automatic random_item();
      int kind, row, col, phi, pos;
      func_type f;
      kind = $urandom_range(0, 99);
      phi = ($urandom_range(0, 9) == 0) ? int'($urandom())
                                         : between(phi_lo - 30000, phi_hi + 30000);
      if (kind < 45) begin
         case ($urandom_range(0, 5))
            0: begin
               f = FUNC_SURF_Q;
               pos = between(head_lo - 30000, HALF_PI - 1);
            end
            1: begin
               f = FUNC_SURF_Q;
               pos = between(HALF_PI, tail_lo + 1000);
            end
            2: begin
               f = FUNC_SURF_Q;
               pos = between(tail_lo, tail_hi + 30000);
            end
            3: begin
               f = FUNC_RAD_Q;
               pos = between(head_lo - 30000, head_hi + 30000);
            end
            4: begin
               f = FUNC_CYL_Q;
               pos = between(cyl_lo - 30000, cyl_hi + 30000);
            end
            default: begin
               f = func_type'(between(FUNC_SURF_Q, FUNC_CYL_Q));
               pos = int'($urandom());
            end
         endcase
         send_item(f, $urandom_range(0, 63), $urandom_range(0, 31), $urandom(), $urandom(),
                   $urandom(), phi, pos);
      end else if (kind < 85) begin
         // in-range rewrite with keys near the current spread
         f = func_type'($urandom_range(FUNC_PHI_WR, FUNC_CYL_WR));
         row = $urandom_range(0, eff_rows - 1);
         case (f)
            FUNC_PHI_WR:  begin col = $urandom_range(0, 31); pos = phi; end
            FUNC_HEAD_WR: begin
               col = $urandom_range(0, eff_head - 1);
               pos = between(head_lo, head_hi);
            end
            FUNC_TAIL_WR: begin
               col = $urandom_range(0, eff_tail - 1);
               pos = between(HALF_PI + 1, tail_hi);
               if (row == 0 && col == 0) tail_lo = pos;
            end
            default: begin
               col = $urandom_range(0, eff_cyl - 1);
               pos = between(cyl_lo, cyl_hi);
            end
         endcase
         send_item(f, row, col, pos, draw_radius(), draw_radius(), $urandom(), $urandom());
      end else if (kind < 95) begin
         // indexes at or beyond the counts in use
         f = func_type'($urandom_range(FUNC_PHI_WR, FUNC_CYL_WR));
         row = (eff_rows < 64 && $urandom_range(0, 1)) ? between(eff_rows, 63)
                                                       : $urandom_range(0, eff_rows - 1);
         col = $urandom_range(0, 31);
         if (f == FUNC_HEAD_WR && row < eff_rows && eff_head < 32) col = between(eff_head, 31);
         if (f == FUNC_TAIL_WR && row < eff_rows && eff_tail < 32) col = between(eff_tail, 31);
         if (f == FUNC_CYL_WR && row < eff_rows && eff_cyl < 32) col = between(eff_cyl, 31);
         if (row < eff_rows && f != FUNC_PHI_WR && col < 32
             && ((f == FUNC_HEAD_WR && col < eff_head) || (f == FUNC_TAIL_WR && col < eff_tail)
                 || (f == FUNC_CYL_WR && col < eff_cyl)))
            f = FUNC_UNUSED;
         if (f == FUNC_PHI_WR && row < eff_rows) f = FUNC_UNUSED;
         send_item(f, row, col, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else
         send_item(FUNC_UNUSED, $urandom_range(0, 63), $urandom_range(0, 31), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom());
   endtask

   // phases: register values, extremes and out-of-range raw values among them
   initial begin
      int rows_raw[PHASES] = '{3, 2, 64, 0, 127, 0};
      int head_raw[PHASES] = '{3, 2, 32, 63, 0, 0};
      int tail_raw[PHASES] = '{3, 2, 32, 1, 5, 0};
      int cyl_raw[PHASES]  = '{3, 2, 32, 40, 2, 0};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            rows_raw[p] = $urandom_range(2, 10);
            head_raw[p] = $urandom_range(2, 8);
            tail_raw[p] = $urandom_range(2, 8);
            cyl_raw[p] = $urandom_range(2, 8);
         end
         wait_drained();
         write_register(REG_ROW_COUNT, rows_raw[p]);
         write_register(REG_HEAD_COLS, head_raw[p]);
         write_register(REG_TAIL_COLS, tail_raw[p]);
         write_register(REG_CYL_COLS, cyl_raw[p]);
         eff_rows = clamp_count(rows_raw[p], MAX_ROWS);
         eff_head = clamp_count(head_raw[p], MAX_COLUMNS);
         eff_tail = clamp_count(tail_raw[p], MAX_COLUMNS);
         eff_cyl = clamp_count(cyl_raw[p], MAX_COLUMNS);
         // the large phase runs back to back on both sides
         idle_off = (p == 2);
         fill_tables();
         if (p == 0) directed_items();
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == 100 && p == 1) hold_request = 1;
            // pause the sender until everything is back
            if (n == RANDOM_PER_PHASE / 2) begin
               end_burst();
               wait_drained();
            end
            random_item();
         end
         end_burst();
      end
      idle_off = 0;
      wait_drained();
      repeat (300) @(posedge clock);
      $display("ran %0d items, %0d of them lookups, over %0d register settings",
               item_count, query_count, PHASES);
      $display("settings ranged from 2 rows and 2 columns to 64 rows and 32 columns");
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
